@@ src/sha_pkg.sv @@
// SHA-256/224 package: round constants, initial hashes, round functions.
// No dependencies.
package sha_pkg;

  localparam int WordW   = 32;
  localparam int Rounds  = 64;
  localparam logic OP_ABSORB   = 1'b0;
  localparam logic OP_FINALIZE = 1'b1;
  localparam logic MODE_256    = 1'b0;
  localparam logic MODE_224    = 1'b1;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic word_t init_hash(input logic mode, input logic [2:0] i);
    word_t h256 [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    word_t h224 [8] = '{32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
                        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};
    return (mode == MODE_224) ? h224[i] : h256[i];
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction
  function automatic word_t ssig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction
  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction
  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

@@ src/sha_if.sv @@
// Valid/ready channel interfaces for the SHA engine.
// No dependencies.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  modport source (output valid, operation, data_byte, input ready);
  modport sink   (input valid, operation, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;
  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface

interface sha_cfg_if;
  logic valid;
  logic ready;
  logic mode;
  modport source (output valid, mode, input ready);
  modport sink   (input valid, mode, output ready);
endinterface

@@ src/sha256_hash_engine.sv @@
// SHA-256 / SHA-224 engine: byte absorb, padding, one round per cycle.
// Depends on sha_pkg and the channel interfaces in sha_if.sv.
//
// Channels: in_ch takes requests (operation, data_byte); an absorb request
// adds one byte, a finalize request pads the message and emits the digest on
// out_ch, 8 words for SHA-256 or 7 for SHA-224, index 0 first, last on the
// final word. cfg_ch writes the mode; that reloads the initial hash and
// drops any message in progress.
// Timing: an absorb that does not fill a block only stores the byte. A block fill
// runs the compression: the rounds in S_RND, then the chain update in S_ADD,
// one round of the shared round unit per cycle. Finalize pads a byte per
// cycle up to the length field, runs one or two compressions, then sends
// one digest word per accepted output cycle.
// in_ch.ready is low from a block fill or a finalize until all its work
// and output is done. When out_ch stalls the word is held and the engine
// waits. Reset loads the SHA-256 initial hash and clears the length.
module sha256_hash_engine
  import sha_pkg::*;
(
  input logic       clk,
  input logic       rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch,
  sha_cfg_if.sink   cfg_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state;
  logic        mode;
  logic        fin;       // compression belongs to finalize
  logic        extra;     // a second padded block follows
  word_t       chain [8];
  word_t       wv [8];
  word_t       win [16];
  word_t       blk [16];
  logic [5:0]  pos;
  logic [60:0] msg_len;
  logic [5:0]  rnd;
  logic [2:0]  oidx;

  logic        in_fire, cfg_fire, out_fire;
  logic        last_word;
  logic [63:0] bits;
  word_t       w_t, t1, t2, ch_f, maj_f;
  logic [3:0]  wa;

  assign in_ch.ready  = (state == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state == S_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign last_word = (mode == MODE_224) ? (oidx == 3'd6) : (oidx == 3'd7);
  assign bits = {msg_len, 3'b000};

  assign wa = rnd[3:0];
  always_comb begin
    if (rnd < 6'd16) w_t = win[wa];
    else w_t = ssig1(win[wa - 4'd2]) + win[wa - 4'd7] + ssig0(win[wa - 4'd15]) + win[wa];
    ch_f  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    maj_f = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1 = wv[7] + bsig1(wv[4]) + ch_f + round_k(rnd) + w_t;
    t2 = bsig0(wv[0]) + maj_f;
  end

  assign out_ch.valid       = (state == S_OUT);
  assign out_ch.digest_word = chain[oidx];
  assign out_ch.word_index  = oidx;
  assign out_ch.last        = last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mode    <= MODE_256;
      pos     <= '0;
      msg_len <= '0;
      rnd     <= '0;
      oidx    <= '0;
      fin     <= 1'b0;
      extra   <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= init_hash(MODE_256, 3'(i));
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_fire) begin
            mode    <= cfg_ch.mode;
            pos     <= '0;
            msg_len <= '0;
            for (int i = 0; i < 8; i++) chain[i] <= init_hash(cfg_ch.mode, 3'(i));
          end else if (in_fire) begin
            if (in_ch.operation == OP_ABSORB) begin
              blk[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] <= in_ch.data_byte;
              msg_len <= msg_len + 61'd1;
              pos <= pos + 6'd1;
              if (pos == 6'd63) begin
                state <= S_RND;
                fin   <= 1'b0;
                extra <= 1'b0;
                rnd   <= '0;
                for (int i = 0; i < 16; i++) win[i] <= (i == 15) ?
                  {blk[15][31:8], in_ch.data_byte} : blk[i];
                for (int i = 0; i < 8; i++) wv[i] <= chain[i];
              end
            end else begin
              blk[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] <= PAD_BYTE;
              extra <= (pos >= LEN_POS);
              fin   <= 1'b1;
              pos   <= pos + 6'd1;
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // zero fill to block end, or to the length field of the last block
          if (extra && pos == 6'd0) begin
            // pad byte closed the block
            for (int i = 0; i < 16; i++) win[i] <= blk[i];
            for (int i = 0; i < 8; i++) wv[i] <= chain[i];
            rnd   <= '0;
            state <= S_RND;
          end else if (!extra && pos == LEN_POS) begin
            blk[14] <= bits[63:32];
            blk[15] <= bits[31:0];
            for (int i = 0; i < 14; i++) win[i] <= blk[i];
            win[14] <= bits[63:32];
            win[15] <= bits[31:0];
            for (int i = 0; i < 8; i++) wv[i] <= chain[i];
            rnd   <= '0;
            state <= S_RND;
          end else begin
            blk[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] <= 8'h00;
            pos <= pos + 6'd1;
            if (pos == 6'd63) begin
              for (int i = 0; i < 15; i++) win[i] <= blk[i];
              win[15] <= {blk[15][31:8], 8'h00};
              for (int i = 0; i < 8; i++) wv[i] <= chain[i];
              rnd   <= '0;
              state <= S_RND;
            end
          end
        end
        S_RND: begin
          if (rnd >= 6'd16) win[wa] <= w_t;
          wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
          wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'(Rounds - 1)) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) chain[i] <= chain[i] + wv[i];
          if (!fin) state <= S_IDLE;
          else if (extra) begin
            extra <= 1'b0;
            pos   <= '0;
            state <= S_PAD;
          end else begin
            oidx  <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            oidx <= oidx + 3'd1;
            if (last_word) begin
              state   <= S_IDLE;
              pos     <= '0;
              msg_len <= '0;
              for (int i = 0; i < 8; i++) chain[i] <= init_hash(mode, 3'(i));
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> (state == S_IDLE)) else $error("ready outside idle");
  a_fill_starts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.operation == OP_ABSORB && pos == 6'd63) |=> (state == S_RND && rnd == 6'd0))
    else $error("full block did not start compression");
  a_first_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && $past(state) == S_ADD) |-> (oidx == 3'd0))
    else $error("digest does not start at word 0");
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_ch.last) |=> (state == S_IDLE && pos == 6'd0))
    else $error("engine not reset after digest");
`endif

endmodule
